// File: hdl/sorted_insert_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// sorted insert priority queue assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// sizes, codes and cell control type of the sorted insert priority queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 32;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 5;
    localparam int OCC_W     = 6;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = ((KEY_W + POS_W + 7) / 8) * 8;
    localparam int S_PAD_W   = S_TDATA_W - KEY_W - POS_W;
    localparam int M_TDATA_W = ((KEY_W + OCC_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - KEY_W - OCC_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // per-cell control for one accepted request
    typedef struct packed {
        logic insert;   // insert that fits
        logic remove;   // remove on a non-empty queue
        logic valid;    // cell holds a live entry
        logic tail;     // cell is the first free slot
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/sorted_insert_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_insert_priority_queue
// ascending key store built from a row of compare-and-shift cells
// ---------------------------------------------------------------------------
// The queue holds up to DEPTH keys in ascending order. Every request gets
// one response, held in a register that loads as the request is taken, and a new
// request is taken every cycle as long as the response register is free or
// being drained. All cells compare the new key against their own entry in
// parallel and shift right, shift left or load in the same cycle, so the
// row takes one request per clock while not stalled. Equal keys leave in
// arrival order. Insert on a full queue reports full, remove on an empty
// queue reports empty, and a read at or past the fill level reports out of
// range; in those cases the returned key is zero. Command three does nothing
// and reports ok. Cell contents need no clearing after reset: only entries
// below the fill level are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request side
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] key, [36:32] position, [39:37] zero
    input  wire logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] command
    input  wire logic [spq_pkg::CMD_W-1:0]     s_axis_tuser,
    // response side
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [31:0] key_out, [37:32] occupancy, [39:38] zero
    output logic      [spq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic      [spq_pkg::STATUS_W-1:0]  m_axis_tuser
);

    // request fields
    spq_pkg::cmd_t                 cmd;
    logic [spq_pkg::KEY_W-1:0]     ins_key;
    logic [spq_pkg::POS_W-1:0]     position;
    logic                          req_acc;

    // fill level
    logic [spq_pkg::COUNT_W-1:0]   count_reg;
    logic [spq_pkg::COUNT_W-1:0]   count_next;

    // decoded request
    logic                          ins_ok;
    logic                          rem_ok;
    logic                          rd_ok;
    logic [spq_pkg::KEY_W-1:0]     rd_key;
    logic [spq_pkg::KEY_W-1:0]     res_key;
    spq_pkg::status_t              res_status;

    // cell row
    logic [spq_pkg::KEY_W-1:0]     cell_key [spq_pkg::DEPTH];
    logic                          cell_gt  [spq_pkg::DEPTH];
    spq_pkg::cell_ctrl_t           cell_ctrl [spq_pkg::DEPTH];

    // response register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [spq_pkg::KEY_W-1:0]     key_out_reg;
    logic [spq_pkg::OCC_W-1:0]     occ_reg;
    spq_pkg::status_t              status_reg;

    assign cmd      = spq_pkg::cmd_t'(s_axis_tuser);
    assign ins_key  = s_axis_tdata[spq_pkg::KEY_W-1:0];
    assign position = s_axis_tdata[spq_pkg::KEY_W +: spq_pkg::POS_W];

    // take a request whenever the response slot is empty or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign req_acc       = s_axis_tvalid && s_axis_tready;

    assign ins_ok = (cmd == spq_pkg::CMD_INSERT)
                    && (count_reg < spq_pkg::COUNT_W'(spq_pkg::DEPTH));
    assign rem_ok = (cmd == spq_pkg::CMD_REMOVE) && (count_reg != '0);
    assign rd_ok  = int'(position) < int'(count_reg);

    // read select over the row
    always_comb
    begin
        rd_key = '0;
        for (int i = 0; i < spq_pkg::DEPTH; i++)
        begin
            if (i == int'(position))
            begin
                rd_key = cell_key[i];
            end
        end
    end

    // response and next fill level
    always_comb
    begin
        res_key    = '0;
        res_status = spq_pkg::ST_OK;
        count_next = count_reg;
        case (cmd)
            spq_pkg::CMD_INSERT:
            begin
                if (ins_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    res_status = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                if (rem_ok)
                begin
                    res_key    = cell_key[0];
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    res_status = spq_pkg::ST_EMPTY;
                end
            end
            spq_pkg::CMD_READ:
            begin
                if (rd_ok)
                begin
                    res_key = rd_key;
                end
                else
                begin
                    res_status = spq_pkg::ST_RANGE;
                end
            end
            default:
            begin
                res_key = '0;
            end
        endcase
    end

    // cell row: each cell sees its neighbors and the incoming key
    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        logic                      left_gt;
        logic [spq_pkg::KEY_W-1:0] left_key;
        logic [spq_pkg::KEY_W-1:0] right_key;

        assign cell_ctrl[i].insert = req_acc && ins_ok;
        assign cell_ctrl[i].remove = req_acc && rem_ok;
        assign cell_ctrl[i].valid  = spq_pkg::COUNT_W'(i) < count_reg;
        assign cell_ctrl[i].tail   = spq_pkg::COUNT_W'(i) == count_reg;

        if (i == 0)
        begin : g_head
            assign left_gt  = 1'b0;
            assign left_key = '0;
        end
        else
        begin : g_body
            assign left_gt  = cell_gt[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == spq_pkg::DEPTH - 1)
        begin : g_end
            assign right_key = '0;
        end
        else
        begin : g_mid
            assign right_key = cell_key[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .left_gt   (left_gt),
            .left_key  (left_key),
            .right_key (right_key),
            .ins_key   (ins_key),
            .key       (cell_key[i]),
            .gt        (cell_gt[i])
        );
    end

    // fill level register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req_acc)
        begin
            count_reg <= count_next;
        end
    end

    // response register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (req_acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            key_out_reg <= res_key;
            status_reg  <= res_status;
            occ_reg     <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{spq_pkg::M_PAD_W{1'b0}}, occ_reg, key_out_reg};
    assign m_axis_tuser  = status_reg;

    // checks
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1,
        count_reg <= spq_pkg::COUNT_W'(spq_pkg::DEPTH), "fill level above depth")
    `SPQ_ASSERT_NEXT(a_remove_count, req_acc && rem_ok,
        count_reg == $past(count_reg) - 1'b1, "remove did not drop one entry")
    `SPQ_ASSERT_NOW(a_err_zero_key, out_valid_reg && (status_reg != spq_pkg::ST_OK),
        key_out_reg == '0, "error response carries a key")
    `SPQ_ASSERT_NOW(a_head_order, count_reg >= spq_pkg::COUNT_W'(2),
        cell_key[0] <= cell_key[1], "first two entries out of order")

endmodule

`default_nettype wire

// File: hdl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// one compare-and-shift slot of the sorted row
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                      clk,
    input  wire spq_pkg::cell_ctrl_t       ctrl,
    input  wire logic                      left_gt,
    input  wire logic [spq_pkg::KEY_W-1:0] left_key,
    input  wire logic [spq_pkg::KEY_W-1:0] right_key,
    input  wire logic [spq_pkg::KEY_W-1:0] ins_key,
    output logic      [spq_pkg::KEY_W-1:0] key,
    output logic                           gt
);

    logic [spq_pkg::KEY_W-1:0] key_reg;
    logic [spq_pkg::KEY_W-1:0] key_next;

    // live entry strictly greater than the incoming key
    assign gt = ctrl.valid && (key_reg > ins_key);

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.remove)
        begin
            key_next = right_key;
        end
        else if (ctrl.insert)
        begin
            if (left_gt)
            begin
                key_next = left_key;
            end
            else if (gt || ctrl.tail)
            begin
                key_next = ins_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

`default_nettype wire

// File: dv/sorted_insert_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// sorted_insert_priority_queue_tb
// self-checking stream test of the sorted insert priority queue: directed
// edge cases, then random fill, drain and mixed phases checked against an
// in-bench sorted-array predictor, with random stalls on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_insert_priority_queue_tb;

    localparam int TARGET_REQUESTS = 1950;
    localparam int MAX_GAP         = 6;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct {
        logic [spq_pkg::KEY_W-1:0] key_out;
        spq_pkg::status_t          status;
        logic [spq_pkg::OCC_W-1:0] occupancy;
    } response_t;

    // sorted-array predictor plus the queue of responses still to come
    class spq_scoreboard;
        logic [spq_pkg::KEY_W-1:0] held_keys [spq_pkg::DEPTH];
        int unsigned               fill = 0;
        response_t                 pending [$];
        int unsigned               errors = 0;
        int unsigned               cmd_count [4];
        int unsigned               status_count [4];

        function void note_request(spq_pkg::cmd_t cmd, logic [spq_pkg::KEY_W-1:0] key,
                                   logic [spq_pkg::POS_W-1:0] pos);
            response_t   rsp;
            int unsigned slot;
            int unsigned j;
            rsp.key_out = '0;
            rsp.status  = spq_pkg::ST_OK;
            cmd_count[cmd]++;
            case (cmd)
                spq_pkg::CMD_INSERT:
                begin
                    if (fill >= spq_pkg::DEPTH)
                        rsp.status = spq_pkg::ST_FULL;
                    else
                    begin
                        // land after every entry not greater than the key
                        slot = fill;
                        while (slot > 0 && held_keys[slot-1] > key)
                            slot--;
                        for (j = fill; j > slot; j--)
                            held_keys[j] = held_keys[j-1];
                        held_keys[slot] = key;
                        fill++;
                    end
                end
                spq_pkg::CMD_REMOVE:
                begin
                    if (fill == 0)
                        rsp.status = spq_pkg::ST_EMPTY;
                    else
                    begin
                        rsp.key_out = held_keys[0];
                        for (j = 1; j < fill; j++)
                            held_keys[j-1] = held_keys[j];
                        fill--;
                    end
                end
                spq_pkg::CMD_READ:
                begin
                    if (pos < fill)
                        rsp.key_out = held_keys[pos];
                    else
                        rsp.status = spq_pkg::ST_RANGE;
                end
                default:
                begin
                    // no-op: ok, key zero, nothing changes
                end
            endcase
            rsp.occupancy = fill[spq_pkg::OCC_W-1:0];
            pending.push_back(rsp);
        endfunction

        function void check_response(logic [spq_pkg::KEY_W-1:0] key_out,
                                     spq_pkg::status_t status,
                                     logic [spq_pkg::OCC_W-1:0] occupancy);
            response_t want;
            if (pending.size() == 0)
            begin
                $error("response with no request outstanding: key_out %h status %s",
                       key_out, status.name());
                errors++;
                return;
            end
            want = pending.pop_front();
            status_count[status]++;
            if (key_out !== want.key_out)
            begin
                $error("key_out: expected %h actual %h", want.key_out, key_out);
                errors++;
            end
            if (status !== want.status)
            begin
                $error("status: expected %s actual %s", want.status.name(), status.name());
                errors++;
            end
            if (occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d actual %0d", want.occupancy, occupancy);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [spq_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic [spq_pkg::CMD_W-1:0]       s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [spq_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [spq_pkg::STATUS_W-1:0]    m_axis_tuser;

    spq_scoreboard sb;
    int unsigned   requests_sent;
    int unsigned   idle_cycles = 0;
    bit            sender_burst;

    sorted_insert_priority_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request: optional gap with valid low, then hold until taken
    task automatic send_request(spq_pkg::cmd_t cmd, logic [spq_pkg::KEY_W-1:0] key,
                                logic [spq_pkg::POS_W-1:0] pos);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{spq_pkg::S_PAD_W{1'b0}}, pos, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // duplicates and both extremes show up often
    function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return spq_pkg::KEY_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [spq_pkg::POS_W-1:0] pick_position();
        if (sb.fill == 0 || $urandom_range(0, 1) == 0)
            return spq_pkg::POS_W'($urandom_range(0, 31));
        return spq_pkg::POS_W'($urandom_range(0, sb.fill - 1));
    endfunction

    // weights in percent; what is left goes mostly to reads, a little to no-ops
    task automatic run_phase(int unsigned n, int unsigned insert_pct, int unsigned remove_pct);
        int unsigned   r;
        spq_pkg::cmd_t cmd;
        sender_burst = ($urandom_range(0, 3) == 0);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                cmd = spq_pkg::CMD_INSERT;
            else if (r < insert_pct + remove_pct)
                cmd = spq_pkg::CMD_REMOVE;
            else if (r < 97)
                cmd = spq_pkg::CMD_READ;
            else
                cmd = spq_pkg::CMD_NOP;
            send_request(cmd, pick_key(), pick_position());
        end
    endtask

    // response side: random stalls, bursts with none, one long hold-off
    initial
    begin : receiver
        int unsigned taken;
        int unsigned stall;
        bit          rx_burst;
        bit          held_off;
        taken    = 0;
        rx_burst = 1'b0;
        held_off = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (!held_off && taken >= HOLD_OFF_AFTER)
            begin
                // long stall so the queue backs up into the request side
                held_off = 1'b1;
                stall    = HOLD_OFF_CYCLES;
            end
            else
                stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    // handshake monitor and watchdog; values are seen as they were before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_response(m_axis_tdata[spq_pkg::KEY_W-1:0],
                                  spq_pkg::status_t'(m_axis_tuser),
                                  m_axis_tdata[spq_pkg::KEY_W +: spq_pkg::OCC_W]);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(spq_pkg::cmd_t'(s_axis_tuser),
                                s_axis_tdata[spq_pkg::KEY_W-1:0],
                                s_axis_tdata[spq_pkg::KEY_W +: spq_pkg::POS_W]);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("sorted_insert_priority_queue_tb: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned kind;
        sb            = new();
        requests_sent = 0;
        sender_burst  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= spq_pkg::CMD_INSERT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: read is out of range, remove is empty, no-op is ok
        send_request(spq_pkg::CMD_READ, '0, '0);
        send_request(spq_pkg::CMD_REMOVE, '0, '0);
        send_request(spq_pkg::CMD_NOP, '1, '1);
        // extremes and equal keys, then read every rank and past the end
        send_request(spq_pkg::CMD_INSERT, 32'd5, '0);
        send_request(spq_pkg::CMD_INSERT, '1, '0);
        send_request(spq_pkg::CMD_INSERT, '0, '0);
        send_request(spq_pkg::CMD_INSERT, 32'd5, '1);
        send_request(spq_pkg::CMD_INSERT, 32'h8000_0001, '0);
        for (int p = 0; p < 6; p++)
            send_request(spq_pkg::CMD_READ, '0, spq_pkg::POS_W'(p));
        send_request(spq_pkg::CMD_READ, '0, '1);
        send_request(spq_pkg::CMD_NOP, '0, '0);
        // drain in ascending order, then one remove too many
        repeat (6) send_request(spq_pkg::CMD_REMOVE, '0, '0);
        send_request(spq_pkg::CMD_READ, '0, '0);

        // fill phases run into full, drain phases into empty
        while (requests_sent < TARGET_REQUESTS)
        begin
            kind = $urandom_range(0, 2);
            case (kind)
                0:       run_phase($urandom_range(30, 70), 80, 10);
                1:       run_phase($urandom_range(30, 70), 10, 80);
                default: run_phase($urandom_range(30, 70), 40, 35);
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // let the monitor log the last request before waiting on responses
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d insert, %0d remove, %0d read, %0d no-op",
                 sb.cmd_count[spq_pkg::CMD_INSERT], sb.cmd_count[spq_pkg::CMD_REMOVE],
                 sb.cmd_count[spq_pkg::CMD_READ], sb.cmd_count[spq_pkg::CMD_NOP]);
        $display("responses: %0d ok, %0d full, %0d empty, %0d out of range",
                 sb.status_count[spq_pkg::ST_OK], sb.status_count[spq_pkg::ST_FULL],
                 sb.status_count[spq_pkg::ST_EMPTY], sb.status_count[spq_pkg::ST_RANGE]);
        if (sb.errors == 0)
            $display("sorted_insert_priority_queue_tb: PASS");
        else
            $display("sorted_insert_priority_queue_tb: FAIL");
        $finish;
    end

endmodule

// File: sorted_insert_priority_queue.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_insert_priority_queue.sv
dv/sorted_insert_priority_queue_tb.sv
